// ===== src/nsd_pkg.sv =====
// Shared types and constants for the netstring deframer.
// No dependencies; used by src/netstring_deframer.sv.
`default_nettype none

package nsd_pkg;

    // Widths of the stream fields
    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 30;
    localparam int unsigned KindW   = 2;
    localparam int unsigned TdataW  = 40;   // payload + frame_length, padded to bytes

    // Longest length prefix accepted by default
    localparam int unsigned MaxDigitsDef = 9;

    // Characters of the framing
    localparam logic [ByteW-1:0] ChColon = 8'h3A;
    localparam logic [ByteW-1:0] ChComma = 8'h2C;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;
    localparam logic [ByteW-1:0] ChNine  = 8'h39;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TERM    = 2'd3
    } t_phase;

    typedef enum logic [KindW-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_ABORT   = 2'd2
    } t_kind;

endpackage

`default_nettype wire

// ===== src/netstring_deframer.sv =====
// Netstring deframer top level: parses length, colon, payload and terminator.
// Depends on src/nsd_pkg.sv for types and constants.
//
// Usage
//   Slave channel s_axis_*: one byte of the incoming stream per word.
//   Master channel m_axis_*: one word per payload byte (tuser = payload kind,
//   tlast low) and one word per frame end (tuser = accept or abort, tlast high).
//   Every word carries the declared frame length in tdata[37:8].
//   Bytes of the length prefix, the colon and stray bytes give no word.
// Pipeline and throughput
//   A byte taken waits in the input register; once parsed, its word, if any,
//   goes to the result register that drives m_axis. One byte per cycle is
//   sustained while m_axis_tready is high; the parse step is a single pass of
//   compare and multiply-by-ten logic between the input and result registers.
// Reset
//   i_rst_n low at a clock edge empties both registers and returns the parser
//   to idle, waiting for the first length digit.
// Back-pressure
//   While m_axis_tready is low the result word holds. Bytes that give no word
//   keep flowing; a byte that would give one waits in the input register, and
//   s_axis_tready drops only once that register is also occupied.
`default_nettype none

module netstring_deframer #(
    parameter int unsigned MAX_DIGITS = nsd_pkg::MaxDigitsDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [nsd_pkg::ByteW-1:0]   s_axis_tdata,  // [7:0] data_byte

    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [nsd_pkg::TdataW-1:0]       m_axis_tdata,  // [7:0] payload,
                                                            // [37:8] frame_length,
                                                            // [39:38] zero
    output logic [nsd_pkg::KindW-1:0]        m_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tlast   // last
);

    localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_DIGITS);
    localparam logic [CntW-1:0] CntOne = CntW'(1);

    localparam int unsigned ByteW = nsd_pkg::ByteW;
    localparam int unsigned LenW  = nsd_pkg::LenW;

    // Input register
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;

    // Parser state
    nsd_pkg::t_phase  r_phase, n_phase;
    logic [LenW-1:0]  r_accum, n_accum;
    logic [CntW-1:0]  r_count, n_count;
    logic [LenW-1:0]  r_left,  n_left;

    // Result register
    logic               r_out_valid;
    nsd_pkg::t_kind     r_out_kind;
    logic [ByteW-1:0]   r_out_payload;
    logic               r_out_last;
    logic [LenW-1:0]    r_out_length;

    // Result of the byte in the input register
    logic               res_valid;
    nsd_pkg::t_kind     res_kind;
    logic [ByteW-1:0]   res_payload;
    logic               res_last;

    logic             is_digit;
    logic [LenW-1:0]  digit_val;
    logic [LenW-1:0]  accum_x10;
    logic             out_free;
    logic             proc_fire;

    assign is_digit  = (r_in_byte >= nsd_pkg::ChZero) && (r_in_byte <= nsd_pkg::ChNine);
    assign digit_val = LenW'(r_in_byte[3:0]);
    // times ten as 8a + 2a, wrapped to the length width
    assign accum_x10 = {r_accum[LenW-4:0], 3'b000} + {r_accum[LenW-2:0], 1'b0};

    assign out_free      = !r_out_valid || m_axis_tready;
    // a byte that gives no word never waits for the output side
    assign proc_fire     = r_in_valid && (!res_valid || out_free);
    assign s_axis_tready = !r_in_valid || proc_fire;

    // Next parser state
    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_count = r_count;
        n_left  = r_left;
        case (r_phase)
            nsd_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    if (((r_count == CntOne) && (r_accum == '0)) || (r_count >= CntMax)) begin
                        // drop a leading zero, or restart after too many digits
                        n_accum = digit_val;
                        n_count = CntOne;
                        n_phase = nsd_pkg::PH_DIGITS;
                        n_left  = '0;
                    end else begin
                        n_accum = accum_x10 + digit_val;
                        n_count = r_count + CntOne;
                    end
                end else if (r_in_byte == nsd_pkg::ChColon) begin
                    n_left  = r_accum;
                    n_phase = (r_accum == '0) ? nsd_pkg::PH_TERM : nsd_pkg::PH_PAYLOAD;
                end else begin
                    // drop the digits and the stray byte
                    n_accum = '0;
                    n_count = '0;
                    n_phase = nsd_pkg::PH_IDLE;
                    n_left  = '0;
                end
            end
            nsd_pkg::PH_PAYLOAD: begin
                n_left = r_left - LenW'(1);
                if (r_left == LenW'(1)) begin
                    n_phase = nsd_pkg::PH_TERM;
                end
            end
            nsd_pkg::PH_TERM: begin
                if (r_in_byte == nsd_pkg::ChComma) begin
                    n_accum = '0;
                    n_count = '0;
                    n_phase = nsd_pkg::PH_IDLE;
                    n_left  = '0;
                end else begin
                    // abort, then treat the same byte as a possible start
                    n_accum = is_digit ? digit_val : '0;
                    n_count = is_digit ? CntOne : '0;
                    n_phase = is_digit ? nsd_pkg::PH_DIGITS : nsd_pkg::PH_IDLE;
                    n_left  = '0;
                end
            end
            default: begin
                n_accum = is_digit ? digit_val : '0;
                n_count = is_digit ? CntOne : '0;
                n_phase = is_digit ? nsd_pkg::PH_DIGITS : nsd_pkg::PH_IDLE;
                n_left  = '0;
            end
        endcase
    end

    // Result of the current byte
    always_comb begin
        res_valid   = 1'b0;
        res_kind    = nsd_pkg::KIND_PAYLOAD;
        res_payload = '0;
        res_last    = 1'b0;
        case (r_phase)
            nsd_pkg::PH_PAYLOAD: begin
                res_valid   = 1'b1;
                res_payload = r_in_byte;
            end
            nsd_pkg::PH_TERM: begin
                res_valid = 1'b1;
                res_last  = 1'b1;
                res_kind  = (r_in_byte == nsd_pkg::ChComma) ? nsd_pkg::KIND_ACCEPT
                                                            : nsd_pkg::KIND_ABORT;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Input register: take a word whenever there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Parser state: advance once per parsed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nsd_pkg::PH_IDLE;
            r_accum <= '0;
            r_count <= '0;
            r_left  <= '0;
        end else if (proc_fire) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    // Result register: load a new word, or drop the old one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire && res_valid) begin
            r_out_kind    <= res_kind;
            r_out_payload <= res_payload;
            r_out_last    <= res_last;
            r_out_length  <= r_accum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_length, r_out_payload};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== tb/netstring_deframer_test.sv =====
// Self-checking bench for netstring_deframer: directed table, then random framed traffic.
// Depends on src/nsd_pkg.sv and src/netstring_deframer.sv; words are checked
// against an in-bench parser kept in step with every accepted input byte.
`timescale 1ns / 100ps

module netstring_deframer_test;

    localparam int unsigned ByteW  = nsd_pkg::ByteW;
    localparam int unsigned LenW   = nsd_pkg::LenW;
    localparam int unsigned KindW  = nsd_pkg::KindW;
    localparam int unsigned TdataW = nsd_pkg::TdataW;

    // One result word as the block reports it
    typedef struct packed {
        nsd_pkg::t_kind     kind;
        logic [ByteW-1:0]   payload;
        logic               last;
        logic [LenW-1:0]    flen;
    } t_frame_word;

    // One directed byte, with its word typed in where it is plain to see
    typedef struct packed {
        logic [ByteW-1:0]   b;
        logic               typed;
        t_frame_word        w;
    } t_stim_row;

    localparam t_frame_word NoWord     = '0;
    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned RandBytes  = 800;
    localparam int unsigned MaxShown   = 10;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [ByteW-1:0]       s_axis_tdata  = '0;     // [7:0] data_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [TdataW-1:0]      m_axis_tdata;           // [7:0] payload, [37:8] frame_length,
                                                    // [39:38] zero
    logic [KindW-1:0]       m_axis_tuser;           // [1:0] kind
    logic                   m_axis_tlast;

    // Parser state mirrored in the bench
    nsd_pkg::t_phase        pr_phase  = nsd_pkg::PH_IDLE;
    logic [LenW-1:0]        pr_len    = '0;
    logic [3:0]             pr_digits = '0;
    logic [LenW-1:0]        pr_left   = '0;

    t_frame_word            expected_words[$];
    int unsigned            fault_count = 0;
    int unsigned            bytes_sent  = 0;
    int unsigned            cycle_count = 0;
    int unsigned            rd_hold     = 0;
    logic                   quiet_in    = 1'b0;     // sender idles not at all while set
    logic                   quiet_out   = 1'b0;     // receiver stalls not at all while set

    // Directed bytes: every special case of the framing, extremes of the payload byte
    t_stim_row dir_rows [25] = '{
        '{"x",   1'b0, NoWord},                                 // stray byte while idle
        '{"0",   1'b0, NoWord},
        '{":",   1'b0, NoWord},                                 // zero length: terminator next
        '{",",   1'b1, '{nsd_pkg::KIND_ACCEPT,  8'h00, 1'b1, 30'd0}},
        '{"0",   1'b0, NoWord},                                 // leading zero, dropped by
        '{"2",   1'b0, NoWord},                                 // the digit after it
        '{":",   1'b0, NoWord},
        '{8'h00, 1'b1, '{nsd_pkg::KIND_PAYLOAD, 8'h00, 1'b0, 30'd2}},
        '{8'hFF, 1'b1, '{nsd_pkg::KIND_PAYLOAD, 8'hFF, 1'b0, 30'd2}},
        '{",",   1'b1, '{nsd_pkg::KIND_ACCEPT,  8'h00, 1'b1, 30'd2}},
        '{"1",   1'b0, NoWord},                                 // nine digits held ...
        '{"2",   1'b0, NoWord},
        '{"3",   1'b0, NoWord},
        '{"4",   1'b0, NoWord},
        '{"5",   1'b0, NoWord},
        '{"6",   1'b0, NoWord},
        '{"7",   1'b0, NoWord},
        '{"8",   1'b0, NoWord},
        '{"9",   1'b0, NoWord},
        '{"1",   1'b0, NoWord},                                 // ... a tenth restarts at 1
        '{":",   1'b0, NoWord},
        '{"Z",   1'b1, '{nsd_pkg::KIND_PAYLOAD, 8'h5A, 1'b0, 30'd1}},
        '{"7",   1'b1, '{nsd_pkg::KIND_ABORT,   8'h00, 1'b1, 30'd1}},  // bad terminator
        '{"#",   1'b0, NoWord},                                 // non-colon after digits
        '{"4",   1'b0, NoWord}                                  // digits left waiting
    };

    netstring_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic is_dec(input logic [ByteW-1:0] b);
        return b >= nsd_pkg::ChZero && b <= nsd_pkg::ChNine;
    endfunction

    // A byte that can neither start a length nor pass for a colon or comma
    function automatic logic [ByteW-1:0] stray_byte();
        logic [ByteW-1:0] b;
        do
            b = ByteW'($urandom_range(0, 255));
        while (is_dec(b) || b == nsd_pkg::ChColon || b == nsd_pkg::ChComma);
        return b;
    endfunction

    // Treat a byte as the possible first digit of a new length
    task automatic restart_length(input logic [ByteW-1:0] b);
        pr_len    = is_dec(b) ? LenW'(b - nsd_pkg::ChZero) : '0;
        pr_digits = is_dec(b) ? 4'd1 : 4'd0;
        pr_phase  = is_dec(b) ? nsd_pkg::PH_DIGITS : nsd_pkg::PH_IDLE;
        pr_left   = '0;
    endtask

    // Advance the mirrored parser by one byte; got is set when a word is due
    task automatic parse_byte(input logic [ByteW-1:0] b, output logic got,
                              output t_frame_word w);
        got = 1'b0;
        w   = NoWord;
        case (pr_phase)
            nsd_pkg::PH_DIGITS: begin
                if (is_dec(b)) begin
                    // drop a lone leading zero, or all digits once the prefix is full
                    if ((pr_digits == 4'd1 && pr_len == '0) ||
                        pr_digits >= nsd_pkg::MaxDigitsDef) begin
                        restart_length(b);
                    end else begin
                        pr_len    = LenW'(pr_len * 10) + LenW'(b - nsd_pkg::ChZero);
                        pr_digits = pr_digits + 4'd1;
                    end
                end else if (b == nsd_pkg::ChColon) begin
                    pr_left  = pr_len;
                    pr_phase = (pr_len == '0) ? nsd_pkg::PH_TERM : nsd_pkg::PH_PAYLOAD;
                end else begin
                    restart_length(b);
                end
            end
            nsd_pkg::PH_PAYLOAD: begin
                got     = 1'b1;
                w       = '{nsd_pkg::KIND_PAYLOAD, b, 1'b0, pr_len};
                pr_left = pr_left - 1'b1;
                if (pr_left == '0) pr_phase = nsd_pkg::PH_TERM;
            end
            nsd_pkg::PH_TERM: begin
                got = 1'b1;
                if (b == nsd_pkg::ChComma) begin
                    w         = '{nsd_pkg::KIND_ACCEPT, 8'h00, 1'b1, pr_len};
                    pr_phase  = nsd_pkg::PH_IDLE;
                    pr_len    = '0;
                    pr_digits = '0;
                    pr_left   = '0;
                end else begin
                    // abort, then reparse the same byte from idle
                    w = '{nsd_pkg::KIND_ABORT, 8'h00, 1'b1, pr_len};
                    restart_length(b);
                end
            end
            default: restart_length(b);
        endcase
    endtask

    // Offer one byte after a random gap, hold it until taken, then log its word
    task automatic push_byte(input logic [ByteW-1:0] b, input logic typed = 1'b0,
                             input t_frame_word typed_w = NoWord);
        int unsigned gap;
        logic        got;
        t_frame_word w;
        gap = quiet_in ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_byte(b, got, w);
        if (got) expected_words.push_back(typed ? typed_w : w);
        bytes_sent++;
    endtask

    task automatic flag_fault(input string what);
        fault_count++;
        if (fault_count <= MaxShown) $display("[%0d] %s", cycle_count, what);
    endtask

    // Receive side: check every word taken, then draw the stall before the next
    always @(posedge i_clk) begin : rx_side
        t_frame_word want;
        int unsigned stall;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                flag_fault($sformatf("unexpected word: kind %0d payload %02h len %0d last %0b",
                                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[37:8],
                                     m_axis_tlast));
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tuser != want.kind || m_axis_tdata[7:0] != want.payload ||
                    m_axis_tdata[37:8] != want.flen || m_axis_tdata[39:38] != 2'b00 ||
                    m_axis_tlast != want.last) begin
                    flag_fault($sformatf({"word mismatch: expected kind %0d payload %02h ",
                                          "len %0d last %0b, got kind %0d payload %02h ",
                                          "len %0d last %0b pad %0b"},
                                         want.kind, want.payload, want.flen, want.last,
                                         m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[37:8],
                                         m_axis_tlast, m_axis_tdata[39:38]));
                end
            end
        end
        if (rd_hold != 0) begin
            rd_hold       <= rd_hold - 1;
            m_axis_tready <= (rd_hold == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall         = quiet_out ? 0 : $urandom_range(0, 7);
            rd_hold       <= stall;
            m_axis_tready <= (stall == 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      flen;
        int unsigned      plen;
        int unsigned      n;
        string            digits;
        logic [ByteW-1:0] b;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].w);

        // Hold the sender with a length half parsed until every word is in
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        push_byte(nsd_pkg::ChColon);

        while (bytes_sent < RandBytes) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 9) == 0) quiet_in = ~quiet_in;
            if ($urandom_range(0, 9) == 0) quiet_out <= ~quiet_out;

            if ($urandom_range(0, 15) == 0) begin
                // line noise, ending on a byte that cannot lengthen the next prefix
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    b = (i == n - 1) ? stray_byte() : ByteW'($urandom_range(0, 255));
                    push_byte(b);
                end
            end else begin
                flen   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                     : $urandom_range(0, 12);
                digits = $sformatf("%0d", flen);
                if ($urandom_range(0, 9) == 0) begin
                    // full prefix of junk digits, nonzero first so all nine are held
                    push_byte(nsd_pkg::ChZero + ByteW'($urandom_range(1, 9)));
                    repeat (8) push_byte(nsd_pkg::ChZero + ByteW'($urandom_range(0, 9)));
                end else if ($urandom_range(0, 7) == 0) begin
                    push_byte(nsd_pkg::ChZero);
                end
                for (int i = 0; i < digits.len(); i++) push_byte(digits[i]);
                push_byte(($urandom_range(0, 15) == 0) ? stray_byte() : nsd_pkg::ChColon);
                // now and then cut the payload short, so the next bytes fill it
                plen = ($urandom_range(0, 15) == 0 && flen > 0) ? $urandom_range(0, flen - 1)
                                                                : flen;
                for (int i = 0; i < plen; i++) push_byte(ByteW'($urandom_range(0, 255)));
                push_byte(($urandom_range(0, 7) == 0) ? stray_byte() : nsd_pkg::ChComma);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fault_count == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/nsd_pkg.sv
src/netstring_deframer.sv
tb/netstring_deframer_test.sv
